@@ rtl/core/flow_table_lookup_create_age_defines.svh @@
// Assertion helpers for the flow table back end (flt_back).
// Each expects clk and rst to be in scope.
`ifndef FLOW_TABLE_LOOKUP_CREATE_AGE_DEFINES_SVH
`define FLOW_TABLE_LOOKUP_CREATE_AGE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FLT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FLT_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/flt_pkg.sv @@
package flt_pkg;

  localparam int BUCKETS_DEF   = 1024;
  localparam int MAX_FLOWS_DEF = 4096;
  localparam logic [31:0] TIMEOUT_RESET = 32'd300;

  localparam int ENTRY_W = 12;
  localparam int COUNT_W = 13;

  localparam int MIX_SHL  = 10;
  localparam int MIX_SHR  = 6;
  localparam int FIN_SHL1 = 3;
  localparam int FIN_SHR  = 11;
  localparam int FIN_SHL2 = 15;
  localparam int V6_BYTES = 16;

  localparam logic ACT_LOOKUP = 1'b0;
  localparam logic ACT_SWEEP  = 1'b1;

  typedef struct packed {
    logic        action;
    logic        is_ipv6;
    logic [63:0] src_addr_hi;
    logic [63:0] src_addr_lo;
    logic [63:0] dst_addr_hi;
    logic [63:0] dst_addr_lo;
    logic [15:0] src_port_num;
    logic [15:0] dst_port_num;
    logic [7:0]  proto_num;
    logic [31:0] now_seconds;
  } in_t;

  typedef struct packed {
    logic [ENTRY_W-1:0] entry_index;
    logic               created;
    logic               table_full;
    logic [COUNT_W-1:0] removed_count;
    logic [COUNT_W-1:0] active_flows;
    logic [31:0]        flows_created;
    logic [31:0]        collisions_seen;
  } out_t;

  // Normalized flow key as stored in the node memory.
  typedef struct packed {
    logic [63:0] src_hi;
    logic [63:0] src_lo;
    logic [63:0] dst_hi;
    logic [63:0] dst_lo;
    logic [40:0] ports_proto;
  } key_t;

  typedef struct packed {
    logic        action;
    key_t        key;
    logic [31:0] now;
  } cmd_t;

  typedef struct packed {
    key_t        key;
    logic [31:0] stamp;
  } node_t;

  function automatic logic [31:0] mix(input logic [31:0] h, input logic [31:0] v);
    logic [31:0] t;
    t = h + v;
    t = t + (t << MIX_SHL);
    t = t ^ (t >> MIX_SHR);
    return t;
  endfunction

endpackage

@@ rtl/core/flow_table_lookup_create_age.sv @@
// Lookup: mix the key (IPv6 bytewise, IPv4 by address word), finish the hash,
//   walk the bucket chain entry by entry, then return the hit or, on a miss, create
//   an entry or report a full table. A sweep ages every chain of every bucket.
// Handshake: one item at a time, busy from start until done; the next start is taken
//   in the cycle after the result.
// Reset: synchronous rst, then a clearing pass over every bucket head with busy high.
//   Results strobe on done for one cycle; the receiver cannot stall.
module flow_table_lookup_create_age import flt_pkg::*; #(
  parameter int BUCKETS   = BUCKETS_DEF,
  parameter int MAX_FLOWS = MAX_FLOWS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  in_t         cmd,
  output logic        done,
  output out_t        result,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  localparam int BKT_W = $clog2(BUCKETS);
  localparam int Q_W   = $bits(cmd_t) + BKT_W;

  logic             busy_reg;
  logic             init_done;
  logic [31:0]      idle_timeout;

  logic             push;
  cmd_t             push_cmd;
  logic [BKT_W-1:0] push_bkt;
  logic             q_full;
  logic             q_empty;
  logic             q_pop;
  logic [Q_W-1:0]   q_rdata;
  cmd_t             q_cmd;
  logic [BKT_W-1:0] q_bkt;

  // hold busy from the accepting edge until the result transfer, and while the bucket heads are cleared after reset
  assign busy = busy_reg || !init_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy_reg <= 1'b0;
    end else if (start && !busy) begin
      busy_reg <= 1'b1;
    end else if (done) begin
      busy_reg <= 1'b0;
    end
  end

  // timeout register: ready only while idle
  assign cfg_ready = !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      idle_timeout <= TIMEOUT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      idle_timeout <= cfg_data;
    end
  end

  // front: normalize the key, hash and reduce to a bucket
  flt_front #(.BUCKETS(BUCKETS)) u_front (
    .clk      (clk),
    .rst      (rst),
    .start    (start && !busy),
    .item     (cmd),
    .q_full   (q_full),
    .push     (push),
    .push_cmd (push_cmd),
    .push_bkt (push_bkt)
  );

  // queue between front and back
  flt_queue #(.WIDTH(Q_W)) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata ({push_cmd, push_bkt}),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  assign q_cmd = q_rdata[Q_W-1:BKT_W];
  assign q_bkt = q_rdata[BKT_W-1:0];

  // back: chain walk, create, and age sweep over the table memories
  flt_back #(.BUCKETS(BUCKETS), .MAX_FLOWS(MAX_FLOWS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .timeout   (idle_timeout),
    .q_empty   (q_empty),
    .q_cmd     (q_cmd),
    .q_bkt     (q_bkt),
    .q_pop     (q_pop),
    .init_done (init_done),
    .done      (done),
    .result    (result)
  );

endmodule

@@ rtl/core/flt_front.sv @@
module flt_front import flt_pkg::*; #(
  parameter int BUCKETS = BUCKETS_DEF,
  localparam int BKT_W = $clog2(BUCKETS)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  in_t              item,
  input  logic             q_full,
  output logic             push,
  output cmd_t             push_cmd,
  output logic [BKT_W-1:0] push_bkt
);

  typedef enum logic [3:0] {
    F_IDLE = 4'b0001,
    F_MIX  = 4'b0010,
    F_FIN  = 4'b0100,
    F_PUSH = 4'b1000
  } fstate_t;

  fstate_t          state;
  cmd_t             cmd;
  logic             v6;
  logic [15:0]      sp;
  logic [15:0]      dp;
  logic [7:0]       pr;
  logic [31:0]      h;
  logic [5:0]       step;

  logic [5:0]       base;
  logic [31:0]      mix_val;
  logic [3:0]       bidx;
  logic [63:0]      word;
  logic [5:0]       sh;

  assign base = v6 ? 6'(2 * V6_BYTES) : 6'd2;
  assign bidx = step[4:1];
  assign sh   = {~bidx[2:0], 3'b000};

  always_comb begin
    if (step[0] == 1'b0) begin
      word = bidx[3] ? cmd.key.src_lo : cmd.key.src_hi;
    end else begin
      word = bidx[3] ? cmd.key.dst_lo : cmd.key.dst_hi;
    end
    mix_val = 32'd0;
    if (step < base) begin
      if (v6) begin
        mix_val = {24'd0, 8'(word >> sh)};
      end else begin
        mix_val = step[0] ? cmd.key.dst_lo[31:0] : cmd.key.src_lo[31:0];
      end
    end else if (step == base) begin
      mix_val = {16'd0, sp};
    end else if (step == base + 6'd1) begin
      mix_val = {16'd0, dp};
    end else begin
      mix_val = {24'd0, pr};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      case (state)
        F_IDLE: begin
          if (start) begin
            cmd.action          <= item.action;
            cmd.now             <= item.now_seconds;
            cmd.key.ports_proto <= {item.is_ipv6, item.src_port_num,
                                    item.dst_port_num, item.proto_num};
            // IPv4 keys keep only the low 32 bits of the low address words
            cmd.key.src_hi <= item.is_ipv6 ? item.src_addr_hi : 64'd0;
            cmd.key.dst_hi <= item.is_ipv6 ? item.dst_addr_hi : 64'd0;
            cmd.key.src_lo <= item.is_ipv6 ? item.src_addr_lo
                                           : {32'd0, item.src_addr_lo[31:0]};
            cmd.key.dst_lo <= item.is_ipv6 ? item.dst_addr_lo
                                           : {32'd0, item.dst_addr_lo[31:0]};
            v6   <= item.is_ipv6;
            sp   <= item.src_port_num;
            dp   <= item.dst_port_num;
            pr   <= item.proto_num;
            h    <= 32'd0;
            step <= 6'd0;
            state <= (item.action == ACT_SWEEP) ? F_PUSH : F_MIX;
          end
        end
        F_MIX: begin
          h <= mix(h, mix_val);
          if (step == base + 6'd2) begin
            step  <= 6'd0;
            state <= F_FIN;
          end else begin
            step <= step + 6'd1;
          end
        end
        F_FIN: begin
          case (step[1:0])
            2'd0:    h <= h + (h << FIN_SHL1);
            2'd1:    h <= h ^ (h >> FIN_SHR);
            default: h <= h + (h << FIN_SHL2);
          endcase
          step <= step + 6'd1;
          if (step[1:0] == 2'd2) begin
            state <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (!q_full) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

  assign push     = (state == F_PUSH) && !q_full;
  assign push_cmd = cmd;
  // BUCKETS must be a power of two, unchecked; low hash bits are the bucket
  assign push_bkt = h[BKT_W-1:0];

endmodule

@@ rtl/core/flt_queue.sv @@
module flt_queue import flt_pkg::*; #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             full,
  output logic             empty
);

  logic [WIDTH-1:0] slot [2];
  logic             wp;
  logic             rp;
  logic [1:0]       cnt;

  assign full  = (cnt == 2'd2);
  assign empty = (cnt == 2'd0);
  assign rdata = slot[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wp] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (pop) begin
        rp <= ~rp;
      end
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

@@ rtl/core/flt_back.sv @@
module flt_back import flt_pkg::*; #(
  parameter int BUCKETS   = BUCKETS_DEF,
  parameter int MAX_FLOWS = MAX_FLOWS_DEF,
  localparam int BKT_W = $clog2(BUCKETS),
  localparam int IDX_W = $clog2(MAX_FLOWS),
  localparam int PTR_W = IDX_W + 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [31:0]      timeout,
  input  logic             q_empty,
  input  cmd_t             q_cmd,
  input  logic [BKT_W-1:0] q_bkt,
  output logic             q_pop,
  output logic             init_done,
  output logic             done,
  output out_t             result
);
  `include "flow_table_lookup_create_age_defines.svh"

  localparam logic [PTR_W-1:0] NIL     = PTR_W'(MAX_FLOWS);
  localparam logic [BKT_W-1:0] LAST_BK = BKT_W'(BUCKETS - 1);

  typedef enum logic [10:0] {
    B_CLEAR = 11'b00000000001,
    B_IDLE  = 11'b00000000010,
    B_LHEAD = 11'b00000000100,
    B_LCHK  = 11'b00000001000,
    B_LCMP  = 11'b00000010000,
    B_MISS  = 11'b00000100000,
    B_FGOT  = 11'b00001000000,
    B_SBKT  = 11'b00010000000,
    B_SCUR  = 11'b00100000000,
    B_SCHK  = 11'b01000000000,
    B_SEVAL = 11'b10000000000
  } bstate_t;

  // memories
  logic [PTR_W-1:0] head_mem [BUCKETS];
  node_t            node_mem [MAX_FLOWS];
  logic [PTR_W-1:0] next_mem [MAX_FLOWS];
  logic [IDX_W-1:0] free_mem [MAX_FLOWS];
  logic [PTR_W-1:0] head_q;
  node_t            node_q;
  logic [PTR_W-1:0] next_q;
  logic [IDX_W-1:0] free_q;

  logic             head_re, head_we, node_re, node_we, next_we, free_re, free_we;
  logic [BKT_W-1:0] head_raddr, head_waddr;
  logic [PTR_W-1:0] head_wdata, next_wdata;
  logic [IDX_W-1:0] node_addr, next_waddr, free_raddr, free_waddr, free_wdata;

  // registers
  bstate_t          state, state_next;
  cmd_t             cmd, cmd_next;
  logic [BKT_W-1:0] bkt, bkt_next;
  logic [BKT_W-1:0] sbkt, sbkt_next;
  logic [BKT_W-1:0] clr, clr_next;
  logic [PTR_W-1:0] cur, cur_next;
  logic [PTR_W-1:0] prev, prev_next;
  logic [PTR_W-1:0] head, head_next;
  logic [PTR_W-1:0] steps, steps_next;
  logic [PTR_W-1:0] free_count, free_count_next;
  logic [PTR_W-1:0] low_water, low_water_next;
  logic [PTR_W-1:0] active, active_next;
  logic [PTR_W-1:0] removed, removed_next;
  logic [31:0]      created_total, created_total_next;
  logic [31:0]      coll_total, coll_total_next;
  logic             done_next;
  logic [IDX_W-1:0] res_entry, res_entry_next;
  logic             res_created, res_created_next;
  logic             res_full, res_full_next;
  logic [PTR_W-1:0] res_removed, res_removed_next;

  logic [PTR_W-1:0] fc_dec;
  logic [IDX_W-1:0] new_idx;
  logic [31:0]      age;

  assign fc_dec  = free_count - PTR_W'(1);
  assign new_idx = (fc_dec < low_water) ? IDX_W'(MAX_FLOWS - 1) - fc_dec[IDX_W-1:0]
                                        : free_q;
  assign age     = cmd.now - node_q.stamp;

  always_comb begin
    state_next         = state;
    cmd_next           = cmd;
    bkt_next           = bkt;
    sbkt_next          = sbkt;
    clr_next           = clr;
    cur_next           = cur;
    prev_next          = prev;
    head_next          = head;
    steps_next         = steps;
    free_count_next    = free_count;
    low_water_next     = low_water;
    active_next        = active;
    removed_next       = removed;
    created_total_next = created_total;
    coll_total_next    = coll_total;
    done_next          = 1'b0;
    res_entry_next     = res_entry;
    res_created_next   = res_created;
    res_full_next      = res_full;
    res_removed_next   = res_removed;
    q_pop      = 1'b0;
    head_re    = 1'b0;
    head_raddr = bkt;
    head_we    = 1'b0;
    head_waddr = bkt;
    head_wdata = NIL;
    node_re    = 1'b0;
    node_we    = 1'b0;
    node_addr  = cur[IDX_W-1:0];
    next_we    = 1'b0;
    next_waddr = prev[IDX_W-1:0];
    next_wdata = next_q;
    free_re    = 1'b0;
    free_raddr = fc_dec[IDX_W-1:0];
    free_we    = 1'b0;
    free_waddr = free_count[IDX_W-1:0];
    free_wdata = cur[IDX_W-1:0];
    case (state)
      B_CLEAR: begin
        head_we    = 1'b1;
        head_waddr = clr;
        clr_next   = clr + BKT_W'(1);
        if (clr == LAST_BK) begin
          state_next = B_IDLE;
        end
      end
      B_IDLE: begin
        if (!q_empty) begin
          q_pop    = 1'b1;
          cmd_next = q_cmd;
          bkt_next = q_bkt;
          if (q_cmd.action == ACT_SWEEP) begin
            sbkt_next    = '0;
            removed_next = '0;
            state_next   = B_SBKT;
          end else begin
            head_re    = 1'b1;
            head_raddr = q_bkt;
            state_next = B_LHEAD;
          end
        end
      end
      B_LHEAD: begin
        head_next  = head_q;
        cur_next   = head_q;
        steps_next = '0;
        state_next = B_LCHK;
      end
      B_LCHK: begin
        if (cur < NIL && steps < NIL) begin
          node_re    = 1'b1;
          state_next = B_LCMP;
        end else begin
          state_next = B_MISS;
        end
      end
      B_LCMP: begin
        if (node_q.key == cmd.key) begin
          done_next        = 1'b1;
          res_entry_next   = cur[IDX_W-1:0];
          res_created_next = 1'b0;
          res_full_next    = 1'b0;
          res_removed_next = '0;
          state_next       = B_IDLE;
        end else begin
          coll_total_next = coll_total + 32'd1;
          cur_next        = next_q;
          steps_next      = steps + PTR_W'(1);
          state_next      = B_LCHK;
        end
      end
      B_MISS: begin
        if (free_count == '0) begin
          done_next        = 1'b1;
          res_entry_next   = '0;
          res_created_next = 1'b0;
          res_full_next    = 1'b1;
          res_removed_next = '0;
          state_next       = B_IDLE;
        end else begin
          free_re    = 1'b1;
          state_next = B_FGOT;
        end
      end
      B_FGOT: begin
        node_we    = 1'b1;
        node_addr  = new_idx;
        next_we    = 1'b1;
        next_waddr = new_idx;
        next_wdata = head;
        head_we    = 1'b1;
        head_wdata = {1'b0, new_idx};
        free_count_next = fc_dec;
        if (fc_dec < low_water) begin
          low_water_next = fc_dec;
        end
        active_next        = active + PTR_W'(1);
        created_total_next = created_total + 32'd1;
        done_next          = 1'b1;
        res_entry_next     = new_idx;
        res_created_next   = 1'b1;
        res_full_next      = 1'b0;
        res_removed_next   = '0;
        state_next         = B_IDLE;
      end
      B_SBKT: begin
        head_re    = 1'b1;
        head_raddr = sbkt;
        state_next = B_SCUR;
      end
      B_SCUR: begin
        cur_next   = head_q;
        prev_next  = NIL;
        steps_next = '0;
        state_next = B_SCHK;
      end
      B_SCHK: begin
        if (cur < NIL && steps < NIL) begin
          node_re    = 1'b1;
          state_next = B_SEVAL;
        end else if (sbkt == LAST_BK) begin
          done_next        = 1'b1;
          res_entry_next   = '0;
          res_created_next = 1'b0;
          res_full_next    = 1'b0;
          res_removed_next = removed;
          state_next       = B_IDLE;
        end else begin
          sbkt_next  = sbkt + BKT_W'(1);
          state_next = B_SBKT;
        end
      end
      B_SEVAL: begin
        steps_next = steps + PTR_W'(1);
        cur_next   = next_q;
        if (age > timeout) begin
          // unlink, keeping the survivors in order
          if (prev < NIL) begin
            next_we = 1'b1;
          end else begin
            head_we    = 1'b1;
            head_waddr = sbkt;
            head_wdata = next_q;
          end
          if (free_count < NIL) begin
            free_we         = 1'b1;
            free_count_next = free_count + PTR_W'(1);
          end
          if (active != '0) begin
            active_next = active - PTR_W'(1);
          end
          removed_next = removed + PTR_W'(1);
        end else begin
          prev_next = cur;
        end
        state_next = B_SCHK;
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (head_we) begin
      head_mem[head_waddr] <= head_wdata;
    end
    if (head_re) begin
      head_q <= head_mem[head_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (node_we) begin
      node_mem[node_addr] <= '{key: cmd.key, stamp: cmd.now};
    end
    if (node_re) begin
      node_q <= node_mem[node_addr];
      next_q <= next_mem[node_addr];
    end
    if (next_we) begin
      next_mem[next_waddr] <= next_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (free_we) begin
      free_mem[free_waddr] <= free_wdata;
    end
    if (free_re) begin
      free_q <= free_mem[free_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= B_CLEAR;
      clr           <= '0;
      free_count    <= NIL;
      low_water     <= NIL;
      active        <= '0;
      created_total <= 32'd0;
      coll_total    <= 32'd0;
      done          <= 1'b0;
    end else begin
      state         <= state_next;
      clr           <= clr_next;
      free_count    <= free_count_next;
      low_water     <= low_water_next;
      active        <= active_next;
      created_total <= created_total_next;
      coll_total    <= coll_total_next;
      done          <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    cmd         <= cmd_next;
    bkt         <= bkt_next;
    sbkt        <= sbkt_next;
    cur         <= cur_next;
    prev        <= prev_next;
    head        <= head_next;
    steps       <= steps_next;
    removed     <= removed_next;
    res_entry   <= res_entry_next;
    res_created <= res_created_next;
    res_full    <= res_full_next;
    res_removed <= res_removed_next;
  end

  assign init_done = (state != B_CLEAR);

  assign result.entry_index     = ENTRY_W'(res_entry);
  assign result.created         = res_created;
  assign result.table_full      = res_full;
  assign result.removed_count   = COUNT_W'(res_removed);
  assign result.active_flows    = COUNT_W'(active);
  assign result.flows_created   = created_total;
  assign result.collisions_seen = coll_total;

  `FLT_ASSERT_IMP(a_pool_balance, 1'b1, (PTR_W+1)'(free_count) + (PTR_W+1)'(active) == (PTR_W+1)'(MAX_FLOWS), "free pool and active count out of balance")
  `FLT_ASSERT_NXT(a_done_single, done, !done, "two results for one item")
  `FLT_ASSERT_IMP(a_result_excl, done, !(res_created && res_full), "created and table_full together")

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
  import flt_pkg::*;

  localparam int NIL = MAX_FLOWS_DEF;
  localparam int STALL_LIMIT = 100000;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  in_t cmd;
  logic done;
  out_t result;
  logic cfg_valid;
  logic cfg_ready;
  logic [31:0] cfg_data;

  flow_table_lookup_create_age dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .done(done), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // Shadow copy of the flow table.
  logic [12:0] head_q [BUCKETS_DEF];
  key_t node_key [MAX_FLOWS_DEF];
  logic [31:0] node_seen [MAX_FLOWS_DEF];
  logic [12:0] node_link [MAX_FLOWS_DEF];
  logic [11:0] free_pool [MAX_FLOWS_DEF];
  int free_cnt;
  int active_cnt;
  logic [31:0] created_cnt;
  logic [31:0] collide_cnt;
  logic [31:0] timeout_q;

  out_t flow_results_q [$];
  int err_cnt;
  int stall_cnt;
  logic [31:0] clock_now;
  bit no_gaps;

  // Recently used keys, reused so that lookups hit existing entries.
  in_t key_pool [64];

  typedef struct {
    in_t  c;
    bit   typed;
    out_t e;
  } row_t;
  row_t rows [$];

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [31:0] oaat_round(input logic [31:0] h, input logic [31:0] v);
    logic [31:0] t;
    t = h + v;
    t = t + (t << 10);
    t = t ^ (t >> 6);
    return t;
  endfunction

  function automatic logic [7:0] addr_octet(input logic [63:0] hi, input logic [63:0] lo,
                                            input int i);
    logic [63:0] w;
    w = (i < 8) ? hi : lo;
    return w[63 - 8 * (i % 8) -: 8];
  endfunction

  // Advance the shadow table by one command and return its result.
  function automatic out_t predict_flow(input in_t c);
    out_t r;
    key_t k;
    logic [31:0] h;
    int b, cur, prev, nxt, steps, n;
    bit hit;
    r = '0;
    if (c.action == ACT_SWEEP) begin
      for (b = 0; b < BUCKETS_DEF; b++) begin
        prev = NIL;
        cur = int'(head_q[b]);
        steps = 0;
        while (cur < NIL && steps < MAX_FLOWS_DEF) begin
          steps++;
          nxt = int'(node_link[cur]);
          if (32'(c.now_seconds - node_seen[cur]) > timeout_q) begin
            if (prev < NIL) node_link[prev] = 13'(nxt);
            else head_q[b] = 13'(nxt);
            if (free_cnt < MAX_FLOWS_DEF) begin
              free_pool[free_cnt] = 12'(cur);
              free_cnt++;
            end
            if (active_cnt > 0) active_cnt--;
            r.removed_count = r.removed_count + 13'd1;
          end else begin
            prev = cur;
          end
          cur = nxt;
        end
      end
    end else begin
      // IPv4 keys keep only the low 32 bits of the low address words; the rest reads as zero.
      k.src_hi = c.is_ipv6 ? c.src_addr_hi : 64'd0;
      k.dst_hi = c.is_ipv6 ? c.dst_addr_hi : 64'd0;
      k.src_lo = c.is_ipv6 ? c.src_addr_lo : {32'd0, c.src_addr_lo[31:0]};
      k.dst_lo = c.is_ipv6 ? c.dst_addr_lo : {32'd0, c.dst_addr_lo[31:0]};
      k.ports_proto = {c.is_ipv6, c.src_port_num, c.dst_port_num, c.proto_num};
      h = 32'd0;
      if (c.is_ipv6) begin
        for (int i = 0; i < 16; i++) begin
          h = oaat_round(h, 32'(addr_octet(k.src_hi, k.src_lo, i)));
          h = oaat_round(h, 32'(addr_octet(k.dst_hi, k.dst_lo, i)));
        end
      end else begin
        h = oaat_round(h, k.src_lo[31:0]);
        h = oaat_round(h, k.dst_lo[31:0]);
      end
      h = oaat_round(h, 32'(c.src_port_num));
      h = oaat_round(h, 32'(c.dst_port_num));
      h = oaat_round(h, 32'(c.proto_num));
      h = h + (h << 3);
      h = h ^ (h >> 11);
      h = h + (h << 15);
      b = int'(h % BUCKETS_DEF);
      cur = int'(head_q[b]);
      steps = 0;
      hit = 1'b0;
      while (cur < NIL && steps < MAX_FLOWS_DEF) begin
        steps++;
        if (node_key[cur] == k) begin
          hit = 1'b1;
          r.entry_index = 12'(cur);
          break;
        end
        collide_cnt++;
        cur = int'(node_link[cur]);
      end
      if (!hit) begin
        if (free_cnt == 0) begin
          r.table_full = 1'b1;
        end else begin
          free_cnt--;
          n = int'(free_pool[free_cnt]);
          node_key[n] = k;
          node_seen[n] = c.now_seconds;
          node_link[n] = head_q[b];
          head_q[b] = 13'(n);
          active_cnt++;
          created_cnt++;
          r.entry_index = 12'(n);
          r.created = 1'b1;
        end
      end
    end
    r.active_flows = 13'(active_cnt);
    r.flows_created = created_cnt;
    r.collisions_seen = collide_cnt;
    return r;
  endfunction

  // Drive one command and hold it until the block takes it.
  task automatic send_cmd(input in_t c, input bit typed, input out_t typed_exp);
    int gap;
    out_t p;
    gap = no_gaps ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    cmd <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
    // Transfer happened at this edge.
    p = predict_flow(c);
    flow_results_q.push_back(typed ? typed_exp : p);
  endtask

  // Drop start, drain, then write the timeout while the block is idle.
  task automatic write_timeout(input logic [31:0] v);
    start <= 1'b0;
    while (flow_results_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    while (busy) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    timeout_q = v;
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic in_t rand_key();
    in_t c;
    c.action = ACT_LOOKUP;
    c.is_ipv6 = 1'($urandom_range(0, 1));
    c.src_addr_hi = rand64();
    c.src_addr_lo = rand64();
    c.dst_addr_hi = rand64();
    c.dst_addr_lo = rand64();
    c.src_port_num = 16'($urandom);
    c.dst_port_num = 16'($urandom);
    c.proto_num = 8'($urandom);
    c.now_seconds = '0;
    return c;
  endfunction

  function automatic in_t next_random_cmd();
    in_t c;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 8) clock_now = $urandom;
    else clock_now = clock_now + $urandom_range(0, 120);
    if (pick < 3) begin
      c = rand_key();
      c.action = ACT_SWEEP;
    end else if (pick < 70) begin
      c = key_pool[$urandom_range(0, 63)];
      // Garbage in the unused IPv4 bits must not change the match.
      if (!c.is_ipv6 && $urandom_range(0, 1)) begin
        c.src_addr_hi = rand64();
        c.dst_addr_hi = rand64();
        c.src_addr_lo[63:32] = $urandom;
        c.dst_addr_lo[63:32] = $urandom;
      end
    end else begin
      c = rand_key();
      if ($urandom_range(0, 3) == 0) key_pool[$urandom_range(0, 63)] = c;
    end
    c.now_seconds = clock_now;
    return c;
  endfunction

  task automatic run_random(input int count);
    for (int i = 0; i < count; i++) begin
      if (i % 50 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      send_cmd(next_random_cmd(), 1'b0, '0);
    end
    no_gaps = 1'b0;
  endtask

  function automatic in_t v4_cmd(input logic [31:0] s, input logic [31:0] d,
                                 input logic [15:0] sp, input logic [15:0] dp,
                                 input logic [7:0] pr, input logic [31:0] t);
    in_t c;
    c = '0;
    c.src_addr_lo = {32'd0, s};
    c.dst_addr_lo = {32'd0, d};
    c.src_port_num = sp;
    c.dst_port_num = dp;
    c.proto_num = pr;
    c.now_seconds = t;
    return c;
  endfunction

  function automatic row_t mk_row(input in_t c, input bit typed, input out_t e);
    row_t r;
    r.c = c;
    r.typed = typed;
    r.e = e;
    return r;
  endfunction

  function automatic out_t mk_out(input int idx, input bit cr, input int act,
                                  input int fc, input int co);
    out_t o;
    o = '0;
    o.entry_index = 12'(idx);
    o.created = cr;
    o.active_flows = 13'(act);
    o.flows_created = 32'(fc);
    o.collisions_seen = 32'(co);
    return o;
  endfunction

  // Compare every result with the oldest expectation.
  always @(posedge clk) begin
    out_t e;
    if (!rst && done) begin
      if (flow_results_q.size() == 0) begin
        err_cnt++;
        $display("%0t: result with nothing expected: %p", $time, result);
      end else begin
        e = flow_results_q.pop_front();
        if (result.entry_index !== e.entry_index || result.created !== e.created ||
            result.table_full !== e.table_full || result.removed_count !== e.removed_count ||
            result.active_flows !== e.active_flows ||
            result.flows_created !== e.flows_created ||
            result.collisions_seen !== e.collisions_seen) begin
          err_cnt++;
          $display("%0t: mismatch expected %p actual %p", $time, e, result);
        end
      end
    end
  end

  // Watchdog: count cycles with no transfer of any kind.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      stall_cnt <= 0;
    end else begin
      stall_cnt <= stall_cnt + 1;
      if (stall_cnt >= STALL_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    in_t c;
    in_t a;
    int fill_n;
    rst = 1'b1;
    start = 1'b0;
    cmd = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    err_cnt = 0;
    stall_cnt = 0;
    no_gaps = 1'b0;
    clock_now = 32'd1000;
    for (int i = 0; i < BUCKETS_DEF; i++) head_q[i] = 13'(NIL);
    for (int i = 0; i < MAX_FLOWS_DEF; i++) begin
      free_pool[i] = 12'(MAX_FLOWS_DEF - 1 - i);
      node_link[i] = 13'(NIL);
    end
    free_cnt = MAX_FLOWS_DEF;
    active_cnt = 0;
    created_cnt = '0;
    collide_cnt = '0;
    timeout_q = TIMEOUT_RESET;
    for (int i = 0; i < 64; i++) key_pool[i] = rand_key();

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: first entries are handed out from index 0 upward.
    a = v4_cmd(32'hC0A8_0001, 32'h0A00_0001, 16'd1234, 16'd80, 8'd6, 32'd1000);
    rows.push_back(mk_row(a, 1'b1, mk_out(0, 1'b1, 1, 1, 0)));
    c = a;
    c.now_seconds = 32'd5000;
    rows.push_back(mk_row(c, 1'b1, mk_out(0, 1'b0, 1, 1, 0)));
    // Same IPv4 key with the ignored upper bits set still hits.
    c.src_addr_hi = '1;
    c.dst_addr_hi = '1;
    c.src_addr_lo[63:32] = '1;
    c.dst_addr_lo[63:32] = '1;
    rows.push_back(mk_row(c, 1'b0, '0));
    c = '1;
    c.action = ACT_LOOKUP;
    rows.push_back(mk_row(c, 1'b0, '0));
    c = '0;
    c.is_ipv6 = 1'b1;
    rows.push_back(mk_row(c, 1'b0, '0));
    c = '0;
    rows.push_back(mk_row(c, 1'b0, '0));
    c = v4_cmd('1, '1, '1, '1, '1, '1);
    rows.push_back(mk_row(c, 1'b0, '0));
    c = a;
    c.is_ipv6 = 1'b1;
    rows.push_back(mk_row(c, 1'b0, '0));
    c = '0;
    c.action = ACT_SWEEP;
    c.now_seconds = 32'd1000;
    rows.push_back(mk_row(c, 1'b0, '0));
    c.now_seconds = 32'd1300;
    rows.push_back(mk_row(c, 1'b0, '0));
    c.now_seconds = 32'hFFFF_FFFF;
    rows.push_back(mk_row(c, 1'b0, '0));
    c = '1;
    c.action = ACT_SWEEP;
    rows.push_back(mk_row(c, 1'b0, '0));
    rows.push_back(mk_row(a, 1'b0, '0));
    foreach (rows[i]) send_cmd(rows[i].c, rows[i].typed, rows[i].e);

    // Random phases over several timeouts, extremes included.
    write_timeout(32'd0);
    run_random(400);
    write_timeout(32'hFFFF_FFFF);
    run_random(400);
    write_timeout($urandom_range(50, 500));
    run_random(700);

    // A burst of unique keys, one second apart.
    fill_n = 0;
    while (fill_n < 90) begin
      fill_n++;
      clock_now = clock_now + 32'd1;
      c = v4_cmd(32'hA000_0000 + 32'(created_cnt), $urandom, 16'($urandom),
                 16'($urandom), 8'($urandom), clock_now);
      send_cmd(c, 1'b0, '0);
    end
    c = key_pool[0];
    c.now_seconds = clock_now;
    send_cmd(c, 1'b0, '0);
    write_timeout(32'd10);
    c = '0;
    c.action = ACT_SWEEP;
    c.now_seconds = clock_now + 32'd2000;
    send_cmd(c, 1'b0, '0);
    run_random(40);

    // Drain, then keep the clock running so that stray results still show.
    start <= 1'b0;
    while (flow_results_q.size() != 0) @(posedge clk);
    repeat (12000) @(posedge clk);
    if (err_cnt == 0 && flow_results_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/flt_pkg.sv
rtl/core/flt_front.sv
rtl/core/flt_queue.sv
rtl/core/flt_back.sv
rtl/core/flow_table_lookup_create_age.sv
bench/tb_top.sv
